[rtl/core/timed_action_scheduler_top_defines.svh]
// assertion helpers for the scheduler top level
`ifndef TIMED_ACTION_SCHEDULER_TOP_DEFINES_SVH
`define TIMED_ACTION_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define TAS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// next-cycle implication, disabled while reset is high
`define TAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

[rtl/core/tas_pkg.sv]
package tas_pkg;

   // schedule size and derived widths
   localparam int SLOTS     = 8;
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAX_RES   = 8;
   localparam int RES_CNT_W = $clog2(MAX_RES + 1);

   localparam int TIME_W = 16;
   localparam int CODE_W = 8;
   localparam int ACT_W  = 2;
   localparam int TGT_W  = 3;
   localparam int LVL_W  = 8;

   // payload range bounds
   localparam logic [CODE_W-1:0] KEY_LAST        = 8'hA4;
   localparam logic [CODE_W-1:0] MOD_FIRST       = 8'hE0;
   localparam logic [CODE_W-1:0] MOD_LAST        = 8'hE7;
   localparam logic [CODE_W-1:0] LAYER_FIRST     = 8'hD0;
   localparam logic [CODE_W-1:0] LAYER_LAST      = 8'hDF;
   localparam logic [CODE_W-1:0] JOY_FIRST       = 8'hB0;
   localparam logic [CODE_W-1:0] JOY_LAST        = 8'hCF;
   localparam logic [CODE_W-1:0] MOUSE_FIRST     = 8'hA5;
   localparam logic [CODE_W-1:0] MOUSE_LAST      = 8'hAA;
   localparam logic [CODE_W-1:0] LOCK_CODE       = 8'hFF;
   localparam logic [CODE_W-1:0] MOUSE_AXIS_LAST = 8'h0F;
   localparam logic [CODE_W-1:0] JOY_AXIS_FIRST  = 8'h20;
   localparam logic [CODE_W-1:0] JOY_AXIS_LAST   = 8'h2F;

   typedef enum logic [1:0] {
      SRC_ANALOG    = 2'd0,
      SRC_MOMENTARY = 2'd1,
      SRC_TOGGLE    = 2'd2,
      SRC_SPECIAL   = 2'd3
   } route_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_SET    = 2'd0,
      ACT_UNSET  = 2'd1,
      ACT_TOGGLE = 2'd2
   } action_type;

   typedef enum logic [TGT_W-1:0] {
      TGT_KEYBOARD   = 3'd0,
      TGT_MOUSE_BTN  = 3'd1,
      TGT_JOY_BTN    = 3'd2,
      TGT_LAYER      = 3'd3,
      TGT_LOCK       = 3'd4,
      TGT_MOUSE_AXIS = 3'd5,
      TGT_JOY_AXIS   = 3'd6,
      TGT_IGNORED    = 3'd7
   } target_type;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_ANALOG  = 2'd1,
      CMD_ENQUEUE = 2'd2,
      CMD_TICK    = 2'd3
   } cmd_kind_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_SCAN    = 2'd1,
      S_REPLACE = 2'd2,
      S_DONE    = 2'd3
   } state_type;

   // decoded request handed to the engine
   typedef struct packed {
      cmd_kind_type        kind;
      logic [CODE_W-1:0]   payload;
      logic [LVL_W-1:0]    depth;
      logic [ACT_W-1:0]    action;
      logic [TIME_W-1:0]   value;
   } cmd_type;

   // one result word
   typedef struct packed {
      logic [TGT_W-1:0]  target;
      logic [CODE_W-1:0] code;
      logic [ACT_W-1:0]  action;
      logic [LVL_W-1:0]  level;
      logic              last;
   } rsp_type;

   // one schedule entry as stored in the slot memory
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [ACT_W-1:0]  action;
      logic [TIME_W-1:0] tleft;
   } slot_type;

   typedef struct packed {
      logic [TGT_W-1:0]  target;
      logic [CODE_W-1:0] code;
   } class_type;

   // map a dispatched payload to target and rebased code
   function automatic class_type classify_dispatch(input logic [CODE_W-1:0] pl);
      class_type c;
      c.code = pl;
      if (pl <= KEY_LAST || (pl >= MOD_FIRST && pl <= MOD_LAST)) begin
         c.target = TGT_KEYBOARD;
      end else if (pl >= LAYER_FIRST && pl <= LAYER_LAST) begin
         c.target = TGT_LAYER;
         c.code   = pl - LAYER_FIRST;
      end else if (pl >= JOY_FIRST && pl <= JOY_LAST) begin
         c.target = TGT_JOY_BTN;
         c.code   = pl - JOY_FIRST;
      end else if (pl >= MOUSE_FIRST && pl <= MOUSE_LAST) begin
         c.target = TGT_MOUSE_BTN;
         c.code   = pl - MOUSE_FIRST;
      end else if (pl == LOCK_CODE) begin
         c.target = TGT_LOCK;
      end else begin
         c.target = TGT_IGNORED;
      end
      return c;
   endfunction

   // map an analog payload to its axis target
   function automatic logic [TGT_W-1:0] classify_analog(input logic [CODE_W-1:0] pl);
      logic [TGT_W-1:0] t;
      if (pl <= MOUSE_AXIS_LAST) begin
         t = TGT_MOUSE_AXIS;
      end else if (pl >= JOY_AXIS_FIRST && pl <= JOY_AXIS_LAST) begin
         t = TGT_JOY_AXIS;
      end else begin
         t = TGT_IGNORED;
      end
      return t;
   endfunction

endpackage

[rtl/core/tas_ram.sv]
module tas_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tas_sub.sv]
module tas_sub (
   input  logic [tas_pkg::TIME_W-1:0] op_a,
   input  logic [tas_pkg::TIME_W-1:0] op_b,
   output logic [tas_pkg::TIME_W-1:0] diff,
   output logic                       borrow,
   output logic                       zero
);

   // shared subtract and compare: borrow means op_a < op_b
   always_comb begin
      {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
      zero = (diff == '0);
   end

endmodule

[rtl/core/tas_engine.sv]
module tas_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_go,
   input  tas_pkg::cmd_type cmd,
   output logic             busy,
   output logic             rsp_valid,
   output tas_pkg::rsp_type rsp
);

   localparam int IW = tas_pkg::IDX_W;

   tas_pkg::state_type state_ff, state_in;
   tas_pkg::cmd_type   cmd_ff, cmd_in;
   logic [IW-1:0]      pidx_ff, pidx_in;
   logic [IW-1:0]      lid_ff, lid_in;
   logic [tas_pkg::TIME_W-1:0]    longest_ff, longest_in;
   logic [tas_pkg::RES_CNT_W-1:0] nres_ff, nres_in;
   tas_pkg::rsp_type   pend_ff, pend_in;
   logic               pend_vld_ff, pend_vld_in;
   tas_pkg::rsp_type   out_ff, out_in;
   logic               out_vld_ff, out_vld_in;
   logic [tas_pkg::SLOTS-1:0] valid_ff, valid_in;

   // slot memory ports
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   tas_pkg::slot_type  wr_data;
   logic [IW-1:0]      rd_addr;
   logic [$bits(tas_pkg::slot_type)-1:0] rd_raw;
   tas_pkg::slot_type  rd_slot;

   // shared subtractor
   logic [tas_pkg::TIME_W-1:0] sub_a, sub_b, sub_diff;
   logic                       sub_borrow, sub_zero;

   logic               last_slot, occupied, due, is_tick;
   tas_pkg::class_type cls;
   tas_pkg::rsp_type   new_res;

   tas_ram #(
      .WIDTH ($bits(tas_pkg::slot_type)),
      .DEPTH (tas_pkg::SLOTS),
      .ADDR_W(IW)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   assign rd_slot = tas_pkg::slot_type'(rd_raw);

   tas_sub u_sub (
      .op_a  (sub_a),
      .op_b  (sub_b),
      .diff  (sub_diff),
      .borrow(sub_borrow),
      .zero  (sub_zero)
   );

   // slot status and subtractor operand select
   always_comb begin
      last_slot = (pidx_ff == IW'(tas_pkg::SLOTS - 1));
      occupied  = valid_ff[pidx_ff];
      is_tick   = (cmd_ff.kind == tas_pkg::CMD_TICK);
      case (state_ff)
         tas_pkg::S_SCAN: begin
            if (is_tick) begin
               sub_a = rd_slot.tleft;
               sub_b = cmd_ff.value;
            end else begin
               sub_a = longest_ff;
               sub_b = rd_slot.tleft;
            end
         end
         tas_pkg::S_REPLACE: begin
            sub_a = cmd_ff.value;
            sub_b = longest_ff;
         end
         default: begin
            sub_a = rd_slot.tleft;
            sub_b = cmd_ff.value;
         end
      endcase
      due = sub_borrow | sub_zero;
      cls = tas_pkg::classify_dispatch(rd_slot.code);
      new_res.target = cls.target;
      new_res.code   = cls.code;
      new_res.action = rd_slot.action;
      new_res.level  = '0;
      new_res.last   = 1'b0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tas_pkg::S_IDLE: begin
            if (cmd_go && (cmd.kind == tas_pkg::CMD_TICK ||
                           cmd.kind == tas_pkg::CMD_ENQUEUE)) begin
               state_in = tas_pkg::S_SCAN;
            end
         end
         tas_pkg::S_SCAN: begin
            if (!is_tick && !occupied) begin
               state_in = tas_pkg::S_IDLE;
            end else if (last_slot) begin
               state_in = is_tick ? tas_pkg::S_DONE : tas_pkg::S_REPLACE;
            end
         end
         tas_pkg::S_REPLACE: state_in = tas_pkg::S_IDLE;
         tas_pkg::S_DONE:    state_in = tas_pkg::S_IDLE;
         default:            state_in = tas_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in      = cmd_ff;
      pidx_in     = pidx_ff;
      lid_in      = lid_ff;
      longest_in  = longest_ff;
      nres_in     = nres_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_in      = out_ff;
      out_vld_in  = 1'b0;
      valid_in    = valid_ff;
      wr_en       = 1'b0;
      wr_addr     = pidx_ff;
      wr_data     = rd_slot;
      rd_addr     = (state_ff == tas_pkg::S_IDLE || last_slot) ? '0 : pidx_ff + IW'(1);
      case (state_ff)
         tas_pkg::S_IDLE: begin
            if (cmd_go) begin
               cmd_in      = cmd;
               pidx_in     = '0;
               lid_in      = '0;
               longest_in  = '0;
               nres_in     = '0;
               pend_vld_in = 1'b0;
               if (cmd.kind == tas_pkg::CMD_ANALOG) begin
                  out_in.target = tas_pkg::classify_analog(cmd.payload);
                  out_in.code   = cmd.payload;
                  out_in.action = tas_pkg::ACT_SET;
                  out_in.level  = cmd.depth;
                  out_in.last   = 1'b1;
                  out_vld_in    = 1'b1;
               end
            end
         end
         tas_pkg::S_SCAN: begin
            pidx_in = pidx_ff + IW'(1);
            if (is_tick) begin
               if (occupied) begin
                  if (due) begin
                     if (nres_ff < tas_pkg::RES_CNT_W'(tas_pkg::MAX_RES)) begin
                        // emit the held word, hold the new one until the next is known
                        valid_in[pidx_ff] = 1'b0;
                        nres_in     = nres_ff + tas_pkg::RES_CNT_W'(1);
                        pend_in     = new_res;
                        pend_vld_in = 1'b1;
                        if (pend_vld_ff) begin
                           out_in     = pend_ff;
                           out_vld_in = 1'b1;
                        end
                     end else begin
                        // result limit reached: keep entry due for the next tick
                        wr_en         = 1'b1;
                        wr_data.tleft = '0;
                     end
                  end else begin
                     wr_en         = 1'b1;
                     wr_data.tleft = sub_diff;
                  end
               end
            end else begin
               if (!occupied) begin
                  // first free slot takes the new entry
                  wr_en              = 1'b1;
                  wr_data.code       = cmd_ff.payload;
                  wr_data.action     = cmd_ff.action;
                  wr_data.tleft      = cmd_ff.value;
                  valid_in[pidx_ff]  = (cmd_ff.payload != '0);
               end else if (sub_borrow) begin
                  longest_in = rd_slot.tleft;
                  lid_in     = pidx_ff;
               end
            end
         end
         tas_pkg::S_REPLACE: begin
            // full schedule: replace the longest entry if the new one is earlier
            if (sub_borrow) begin
               wr_en            = 1'b1;
               wr_addr          = lid_ff;
               wr_data.code     = cmd_ff.payload;
               wr_data.action   = cmd_ff.action;
               wr_data.tleft    = cmd_ff.value;
               valid_in[lid_ff] = (cmd_ff.payload != '0);
            end
         end
         tas_pkg::S_DONE: begin
            if (pend_vld_ff) begin
               out_in      = pend_ff;
               out_in.last = 1'b1;
               out_vld_in  = 1'b1;
            end
            pend_vld_in = 1'b0;
         end
         default: begin
            pend_vld_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tas_pkg::S_IDLE;
         valid_ff    <= '0;
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         out_vld_ff  <= out_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      pidx_ff    <= pidx_in;
      lid_ff     <= lid_in;
      longest_ff <= longest_in;
      nres_ff    <= nres_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end

   assign busy      = (state_ff != tas_pkg::S_IDLE);
   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

endmodule

[rtl/core/timed_action_scheduler_top.sv]
// Timed action scheduler: turns key events into immediate analog words or
// queued set/unset/toggle actions held in a small timed schedule.
// Request channel: drive req_* and raise start; the word is taken at a clock
// edge where start is high and busy is low. req_mode low is a key event,
// high is a time tick carrying req_elapsed.
// Result channel: each word sits on rsp_* for one cycle with rsp_valid high;
// rsp_last marks the final word of a request. The receiver cannot stall.
// Config channel: csr_data is written to the action delay register when
// csr_valid and csr_ready are both high; csr_ready is always high.
// Timing: the slots are walked one per cycle through the slot memory's
// registered read port and one shared subtractor.
//   analog event: not busy, result in the cycle after accept
//   queued event: busy until the walk stops at the first free slot, plus
//     the replace decision state when all are full
//   tick: busy for the whole walk and the done state, results spread over
//     the walk, last one in the cycle where busy drops
// Reset empties every slot at once through per-slot valid bits and clears
// the action delay to zero.
`include "timed_action_scheduler_top_defines.svh"
module timed_action_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [1:0]  req_route,
   input  logic [7:0]  req_payload,
   input  logic [7:0]  req_depth,
   input  logic        req_key_up,
   input  logic        req_key_down,
   input  logic [15:0] req_elapsed,
   output logic        rsp_valid,
   output logic [2:0]  rsp_target,
   output logic [7:0]  rsp_code,
   output logic [1:0]  rsp_action,
   output logic [7:0]  rsp_level,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [tas_pkg::TIME_W-1:0] delay_ff, delay_in;
   tas_pkg::cmd_type cmd;
   tas_pkg::rsp_type rsp;
   logic             cmd_go;

   // action delay register
   assign csr_ready = 1'b1;
   always_comb begin
      delay_in = delay_ff;
      if (csr_valid && csr_ready) begin
         delay_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
      end else begin
         delay_ff <= delay_in;
      end
   end

   // request decode
   always_comb begin
      cmd.payload = req_payload;
      cmd.depth   = req_depth;
      cmd.action  = tas_pkg::ACT_SET;
      cmd.value   = delay_ff;
      cmd.kind    = tas_pkg::CMD_NONE;
      if (req_mode) begin
         cmd.kind  = tas_pkg::CMD_TICK;
         cmd.value = req_elapsed;
      end else begin
         case (tas_pkg::route_type'(req_route))
            tas_pkg::SRC_ANALOG: cmd.kind = tas_pkg::CMD_ANALOG;
            tas_pkg::SRC_MOMENTARY: begin
               if (req_key_down) begin
                  cmd.kind   = tas_pkg::CMD_ENQUEUE;
                  cmd.action = tas_pkg::ACT_SET;
               end else if (req_key_up) begin
                  cmd.kind   = tas_pkg::CMD_ENQUEUE;
                  cmd.action = tas_pkg::ACT_UNSET;
               end
            end
            tas_pkg::SRC_TOGGLE: begin
               if (req_key_down) begin
                  cmd.kind   = tas_pkg::CMD_ENQUEUE;
                  cmd.action = tas_pkg::ACT_TOGGLE;
               end
            end
            default: cmd.kind = tas_pkg::CMD_NONE;
         endcase
      end
   end

   assign cmd_go = start && !busy;

   tas_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmd_go   (cmd_go),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp      (rsp)
   );

   assign rsp_target = rsp.target;
   assign rsp_code   = rsp.code;
   assign rsp_action = rsp.action;
   assign rsp_level  = rsp.level;
   assign rsp_last   = rsp.last;

   // a tick always walks the schedule
   `TAS_ASSERT_NEXT(a_tick_busy, clock, reset, start && !busy && req_mode, busy)
   // a word shown while idle closes its request
   `TAS_ASSERT_SAME(a_idle_last, clock, reset, rsp_valid && !busy, rsp_last)
   // an analog event answers in the next cycle
   `TAS_ASSERT_NEXT(a_analog_rsp, clock, reset,
      start && !busy && !req_mode && req_route == tas_pkg::SRC_ANALOG,
      rsp_valid && rsp_last)

endmodule

[dv/timed_action_scheduler_top_tb.sv]
`timescale 1ns / 1ps
module timed_action_scheduler_top_tb;

   localparam logic MODE_KEY  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // one request as driven on the req_ ports
   typedef struct packed {
      logic               mode;
      tas_pkg::route_type route;
      logic [7:0]         payload;
      logic [7:0]         depth;
      logic               key_up;
      logic               key_down;
      logic [15:0]        elapsed;
   } key_event_type;

   // schedule predictor and store of words still owed by the block
   class action_schedule;
      logic [tas_pkg::TIME_W-1:0] delay_ticks;
      logic [tas_pkg::CODE_W-1:0] entry_code [tas_pkg::SLOTS];
      logic [tas_pkg::ACT_W-1:0]  entry_act  [tas_pkg::SLOTS];
      logic [tas_pkg::TIME_W-1:0] entry_left [tas_pkg::SLOTS];
      tas_pkg::rsp_type           owed_words [$];
      int                         mismatch_count;

      function new();
         delay_ticks    = '0;
         mismatch_count = 0;
         for (int i = 0; i < tas_pkg::SLOTS; i++) begin
            entry_code[i] = '0;
            entry_act[i]  = '0;
            entry_left[i] = '0;
         end
      endfunction

      function int outstanding();
         return owed_words.size();
      endfunction

      // first free slot, else evict the longest wait if the new one is sooner
      function void queue_action(logic [tas_pkg::CODE_W-1:0] pl, tas_pkg::action_type act);
         logic [tas_pkg::TIME_W-1:0] worst_left;
         int                         worst_idx;
         worst_left = '0;
         worst_idx  = 0;
         for (int i = 0; i < tas_pkg::SLOTS; i++) begin
            if (entry_code[i] == '0) begin
               entry_code[i] = pl;
               entry_act[i]  = act;
               entry_left[i] = delay_ticks;
               return;
            end
            if (entry_left[i] > worst_left) begin
               worst_left = entry_left[i];
               worst_idx  = i;
            end
         end
         if (delay_ticks < worst_left) begin
            entry_code[worst_idx] = pl;
            entry_act[worst_idx]  = act;
            entry_left[worst_idx] = delay_ticks;
         end
      endfunction

      // payload ranges in ascending order
      function tas_pkg::rsp_type dispatch_word(logic [tas_pkg::CODE_W-1:0] pl,
                                               logic [tas_pkg::ACT_W-1:0] act);
         tas_pkg::rsp_type w;
         w.code   = pl;
         w.action = act;
         w.level  = '0;
         w.last   = 1'b0;
         if (pl <= tas_pkg::KEY_LAST) begin
            w.target = tas_pkg::TGT_KEYBOARD;
         end else if (pl <= tas_pkg::MOUSE_LAST) begin
            w.target = tas_pkg::TGT_MOUSE_BTN;
            w.code   = pl - tas_pkg::MOUSE_FIRST;
         end else if (pl < tas_pkg::JOY_FIRST) begin
            w.target = tas_pkg::TGT_IGNORED;
         end else if (pl <= tas_pkg::JOY_LAST) begin
            w.target = tas_pkg::TGT_JOY_BTN;
            w.code   = pl - tas_pkg::JOY_FIRST;
         end else if (pl < tas_pkg::LAYER_FIRST) begin
            w.target = tas_pkg::TGT_IGNORED;
         end else if (pl <= tas_pkg::LAYER_LAST) begin
            w.target = tas_pkg::TGT_LAYER;
            w.code   = pl - tas_pkg::LAYER_FIRST;
         end else if (pl >= tas_pkg::MOD_FIRST && pl <= tas_pkg::MOD_LAST) begin
            w.target = tas_pkg::TGT_KEYBOARD;
         end else if (pl == tas_pkg::LOCK_CODE) begin
            w.target = tas_pkg::TGT_LOCK;
         end else begin
            w.target = tas_pkg::TGT_IGNORED;
         end
         return w;
      endfunction

      // update schedule for an accepted request and note the words it owes
      function void note_request(key_event_type ev);
         tas_pkg::rsp_type w;
         int               n;
         n = 0;
         if (ev.mode == MODE_KEY) begin
            case (ev.route)
               tas_pkg::SRC_ANALOG: begin
                  w.target = tas_pkg::TGT_IGNORED;
                  if (ev.payload <= tas_pkg::MOUSE_AXIS_LAST) begin
                     w.target = tas_pkg::TGT_MOUSE_AXIS;
                  end else if (ev.payload >= tas_pkg::JOY_AXIS_FIRST &&
                               ev.payload <= tas_pkg::JOY_AXIS_LAST) begin
                     w.target = tas_pkg::TGT_JOY_AXIS;
                  end
                  w.code   = ev.payload;
                  w.action = tas_pkg::ACT_SET;
                  w.level  = ev.depth;
                  w.last   = 1'b1;
                  owed_words.push_back(w);
               end
               tas_pkg::SRC_MOMENTARY: begin
                  if (ev.key_down) begin
                     queue_action(ev.payload, tas_pkg::ACT_SET);
                  end else if (ev.key_up) begin
                     queue_action(ev.payload, tas_pkg::ACT_UNSET);
                  end
               end
               tas_pkg::SRC_TOGGLE: begin
                  if (ev.key_down) begin
                     queue_action(ev.payload, tas_pkg::ACT_TOGGLE);
                  end
               end
               default: begin
               end
            endcase
         end else begin
            // tick: fire due entries in slot order, age the rest
            for (int i = 0; i < tas_pkg::SLOTS; i++) begin
               if (entry_code[i] != '0) begin
                  if (entry_left[i] <= ev.elapsed) begin
                     if (n < tas_pkg::MAX_RES) begin
                        owed_words.push_back(dispatch_word(entry_code[i], entry_act[i]));
                        n++;
                        entry_code[i] = '0;
                     end else begin
                        entry_left[i] = '0;
                     end
                  end else begin
                     entry_left[i] = entry_left[i] - ev.elapsed;
                  end
               end
            end
            if (n > 0) begin
               w      = owed_words.pop_back();
               w.last = 1'b1;
               owed_words.push_back(w);
            end
         end
      endfunction

      function void compare_field(string field_name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_word(tas_pkg::rsp_type got);
         tas_pkg::rsp_type want;
         if (owed_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual target=%0d code=%0d",
                     $time, got.target, got.code);
            mismatch_count++;
            return;
         end
         want = owed_words.pop_front();
         compare_field("target", int'(want.target), int'(got.target));
         compare_field("code",   int'(want.code),   int'(got.code));
         compare_field("action", int'(want.action), int'(got.action));
         compare_field("level",  int'(want.level),  int'(got.level));
         compare_field("last",   int'(want.last),   int'(got.last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start;
   logic        busy;
   logic        req_mode;
   logic [1:0]  req_route;
   logic [7:0]  req_payload;
   logic [7:0]  req_depth;
   logic        req_key_up;
   logic        req_key_down;
   logic [15:0] req_elapsed;
   logic        rsp_valid;
   logic [2:0]  rsp_target;
   logic [7:0]  rsp_code;
   logic [1:0]  rsp_action;
   logic [7:0]  rsp_level;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   action_schedule sched = new();
   bit             burst_phase = 1'b0;

   timed_action_scheduler_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_route    (req_route),
      .req_payload  (req_payload),
      .req_depth    (req_depth),
      .req_key_up   (req_key_up),
      .req_key_down (req_key_down),
      .req_elapsed  (req_elapsed),
      .rsp_valid    (rsp_valid),
      .rsp_target   (rsp_target),
      .rsp_code     (rsp_code),
      .rsp_action   (rsp_action),
      .rsp_level    (rsp_level),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // every result word is taken at the edge ending its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sched.check_word(tas_pkg::rsp_type'({rsp_target, rsp_code, rsp_action,
                                              rsp_level, rsp_last}));
      end
   end

   function automatic int draw_gap();
      if (burst_phase || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   // present one request and hold it until the block takes it
   task automatic send_request(input key_event_type ev);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_mode     <= ev.mode;
      req_route    <= ev.route;
      req_payload  <= ev.payload;
      req_depth    <= ev.depth;
      req_key_up   <= ev.key_up;
      req_key_down <= ev.key_down;
      req_elapsed  <= ev.elapsed;
      @(posedge clock);
      while (busy) @(posedge clock);
      sched.note_request(ev);
   endtask

   task automatic send_fields(input logic mode, input tas_pkg::route_type route,
                              input logic [7:0] payload, input logic [7:0] depth,
                              input logic up, input logic down, input logic [15:0] elapsed);
      key_event_type ev;
      ev.mode     = mode;
      ev.route    = route;
      ev.payload  = payload;
      ev.depth    = depth;
      ev.key_up   = up;
      ev.key_down = down;
      ev.elapsed  = elapsed;
      send_request(ev);
   endtask

   // drain, let the walk finish, then write the delay register
   task automatic write_delay(input logic [15:0] value);
      start <= 1'b0;
      while (sched.outstanding() != 0) @(posedge clock);
      repeat (tas_pkg::SLOTS + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sched.delay_ticks = value;
      csr_valid <= 1'b0;
   endtask

   function automatic bit has_effect(input key_event_type ev);
      if (ev.mode == MODE_TICK || ev.route == tas_pkg::SRC_ANALOG) begin
         return 1'b1;
      end
      if (ev.route == tas_pkg::SRC_MOMENTARY) begin
         return ev.key_down | ev.key_up;
      end
      if (ev.route == tas_pkg::SRC_TOGGLE) begin
         return ev.key_down;
      end
      return 1'b0;
   endfunction

   // mostly well formed presses and ticks scaled to the current delay
   function automatic key_event_type random_event(input logic [15:0] delay);
      key_event_type ev;
      int            pick;
      int            sub;
      int            scale;
      ev.mode     = MODE_KEY;
      ev.route    = tas_pkg::SRC_ANALOG;
      ev.payload  = ($urandom_range(0, 24) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      ev.depth    = 8'($urandom_range(0, 255));
      ev.key_up   = 1'($urandom_range(0, 1));
      ev.key_down = 1'($urandom_range(0, 1));
      ev.elapsed  = 16'($urandom_range(0, 65535));
      pick        = $urandom_range(0, 99);
      sub         = $urandom_range(0, 19);
      if (pick < 25) begin
         ev.mode = MODE_TICK;
         scale   = int'(delay) / 6 + 2;
         if (sub < 10) begin
            ev.elapsed = 16'($urandom_range(0, scale));
         end else if (sub < 14) begin
            ev.elapsed = '0;
         end else if (sub < 16) begin
            ev.elapsed = delay;
         end
      end else if (pick < 45) begin
         ev.route = tas_pkg::SRC_ANALOG;
      end else if (pick < 75) begin
         ev.route = tas_pkg::SRC_MOMENTARY;
         if (sub < 10) begin
            ev.key_down = 1'b1;
            ev.key_up   = 1'b0;
         end else if (sub < 15) begin
            ev.key_down = 1'b0;
            ev.key_up   = 1'b1;
         end else if (sub < 18) begin
            ev.key_down = 1'b1;
            ev.key_up   = 1'b1;
         end else begin
            ev.key_down = 1'b0;
            ev.key_up   = 1'b0;
         end
      end else if (pick < 93) begin
         ev.route    = tas_pkg::SRC_TOGGLE;
         ev.key_down = (sub < 16);
      end else begin
         ev.route = tas_pkg::SRC_SPECIAL;
      end
      return ev;
   endfunction

   initial begin
      key_event_type ev;
      logic [15:0]   phase_delay [8];
      int            done_items;

      start        <= 1'b0;
      req_mode     <= MODE_KEY;
      req_route    <= tas_pkg::SRC_ANALOG;
      req_payload  <= '0;
      req_depth    <= '0;
      req_key_up   <= 1'b0;
      req_key_down <= 1'b0;
      req_elapsed  <= '0;
      csr_valid    <= 1'b0;
      csr_data     <= '0;

      phase_delay[0] = 16'hFFFF;
      phase_delay[1] = 16'h0001;
      phase_delay[2] = 16'($urandom_range(0, 65535));
      phase_delay[3] = 16'($urandom_range(2, 64));
      phase_delay[4] = 16'h0000;
      phase_delay[5] = 16'h8000;
      phase_delay[6] = 16'($urandom_range(2, 300));
      phase_delay[7] = 16'($urandom_range(0, 65535));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // analog axes, range edges and unclassified payloads
      send_fields(MODE_KEY, tas_pkg::SRC_ANALOG, 8'h00, 8'hFF, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_ANALOG, 8'h0F, 8'h00, 1'b1, 1'b0, 16'hFFFF);
      send_fields(MODE_KEY, tas_pkg::SRC_ANALOG, 8'h10, 8'h55, 1'b0, 1'b0, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_ANALOG, 8'h20, 8'hAA, 1'b1, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_ANALOG, 8'h2F, 8'h01, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_ANALOG, 8'hFF, 8'h80, 1'b0, 1'b0, 16'h0000);
      // special route and key events that queue nothing
      send_fields(MODE_KEY, tas_pkg::SRC_SPECIAL, 8'h04, 8'h00, 1'b1, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_TOGGLE, 8'hCF, 8'h00, 1'b1, 1'b0, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'hD0, 8'h00, 1'b0, 1'b0, 16'h0000);
      // set, unset, down winning over up, toggle; then fire at zero elapsed
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'hA4, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'hA5, 8'h00, 1'b1, 1'b0, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'hAA, 8'h00, 1'b1, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_TOGGLE, 8'hB0, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_TICK, tas_pkg::SRC_ANALOG, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000);
      // fill the schedule, zero payload lost, last one dropped when full
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'hD0, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_TOGGLE, 8'hDF, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'hE0, 8'h00, 1'b1, 1'b0, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'hE7, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_TOGGLE, 8'hFF, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'hAB, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'hFE, 8'h00, 1'b1, 1'b0, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_MOMENTARY, 8'h00, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_TOGGLE, 8'hC0, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_KEY, tas_pkg::SRC_TOGGLE, 8'hCF, 8'h00, 1'b0, 1'b1, 16'h0000);
      send_fields(MODE_TICK, tas_pkg::SRC_ANALOG, 8'h00, 8'h00, 1'b0, 1'b0, 16'hFFFF);

      // random phases, each under its own delay setting
      for (int p = 0; p < 8; p++) begin
         write_delay(phase_delay[p]);
         burst_phase = (p % 3 == 1);
         done_items  = 0;
         while (done_items < 20) begin
            ev = random_event(phase_delay[p]);
            if (has_effect(ev)) begin
               done_items++;
            end
            send_request(ev);
         end
      end

      // flush whatever is still scheduled
      burst_phase = 1'b0;
      send_fields(MODE_TICK, tas_pkg::SRC_ANALOG, 8'h00, 8'h00, 1'b0, 1'b0, 16'hFFFF);
      start <= 1'b0;

      while (sched.outstanding() != 0) @(posedge clock);
      repeat (tas_pkg::SLOTS + 4) @(posedge clock);
      if (sched.mismatch_count == 0) begin
         $display("timed_action_scheduler_top_tb: PASS");
      end else begin
         $display("timed_action_scheduler_top_tb: FAIL");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("timed_action_scheduler_top_tb: FAIL");
      $finish;
   end

endmodule
